>>> rtl/core/cvs_pkg.sv
// Shared types and constants for the cyclic voltammetry staircase sweep core.
// No dependencies; imported by cvs_csr, cvs_engine and the top level.
package cvs_pkg;

   localparam int VOLT_W   = 17;  // signed voltage, 0.1 mV units
   localparam int STEP_W   = 14;
   localparam int CNT_W    = 8;
   localparam int PERIOD_W = 16;
   localparam int POINT_W  = 16;
   localparam int TIME_W   = 32;
   localparam int SMP_W    = 12;
   localparam int WALK_W   = 18;  // walked distance, holds distance plus one step
   localparam int PRES_W   = 19;  // running voltage, start plus walked distance
   localparam int LEG_W    = 2;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_FIELD_W = POINT_W + TIME_W + 2 * SMP_W + VOLT_W + 1;
   localparam int RSP_DATA_W  = 96;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   // op codes carried in req_tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BEGIN_VOLTAGE      = 3'd0,
      REG_VERTEX_ONE_VOLTAGE = 3'd1,
      REG_VERTEX_TWO_VOLTAGE = 3'd2,
      REG_STEP_SIZE          = 3'd3,
      REG_CYCLE_COUNT        = 3'd4,
      REG_PERIOD_MS          = 3'd5
   } csr_index_type;

   localparam logic signed [VOLT_W-1:0] RST_BEGIN_VOLTAGE = '0;
   localparam logic signed [VOLT_W-1:0] RST_VERTEX_VOLTAGE = '0;
   localparam logic [STEP_W-1:0]   RST_STEP_SIZE   = 14'd10;
   localparam logic [CNT_W-1:0]    RST_CYCLE_COUNT = 8'd1;
   localparam logic [PERIOD_W-1:0] RST_PERIOD_MS   = 16'd100;

   // legs of one cycle: begin->vertex one, vertex one->vertex two, vertex two->begin
   typedef enum logic [LEG_W-1:0] {
      LEG_OUT    = 2'd0,
      LEG_ACROSS = 2'd1,
      LEG_BACK   = 2'd2
   } leg_type;

   typedef struct packed {
      logic signed [VOLT_W-1:0] begin_voltage;
      logic signed [VOLT_W-1:0] vertex_one_voltage;
      logic signed [VOLT_W-1:0] vertex_two_voltage;
      logic [STEP_W-1:0]        step_size;
      logic [CNT_W-1:0]         cycle_count;
      logic [PERIOD_W-1:0]      period_ms;
   } cfg_type;

   typedef struct packed {
      logic             op;
      logic [SMP_W-1:0] current_sample;
      logic [SMP_W-1:0] voltage_sample;
   } item_type;

   typedef struct packed {
      logic                     sample_valid;
      logic [POINT_W-1:0]       point_index;
      logic [TIME_W-1:0]        time_ms;
      logic [SMP_W-1:0]         current_out;
      logic [SMP_W-1:0]         voltage_out;
      logic signed [VOLT_W-1:0] setpoint;
      logic                     relay_on;
      logic                     run_done;
   } res_type;

endpackage

>>> rtl/core/cvs_csr.sv
// Configuration register file for the sweep core.
// Depends on cvs_pkg (cfg_type, register index codes, reset values).
module cvs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cvs_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output cvs_pkg::cfg_type               cfg
);
   import cvs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_BEGIN_VOLTAGE:      cfg_in.begin_voltage      = csr_wdata;
            REG_VERTEX_ONE_VOLTAGE: cfg_in.vertex_one_voltage = csr_wdata;
            REG_VERTEX_TWO_VOLTAGE: cfg_in.vertex_two_voltage = csr_wdata;
            REG_STEP_SIZE:          cfg_in.step_size   = csr_wdata[STEP_W-1:0];
            REG_CYCLE_COUNT:        cfg_in.cycle_count = csr_wdata[CNT_W-1:0];
            REG_PERIOD_MS:          cfg_in.period_ms   = csr_wdata[PERIOD_W-1:0];
            default:                cfg_in = cfg_ff;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_voltage      <= RST_BEGIN_VOLTAGE;
         cfg_ff.vertex_one_voltage <= RST_VERTEX_VOLTAGE;
         cfg_ff.vertex_two_voltage <= RST_VERTEX_VOLTAGE;
         cfg_ff.step_size          <= RST_STEP_SIZE;
         cfg_ff.cycle_count        <= RST_CYCLE_COUNT;
         cfg_ff.period_ms          <= RST_PERIOD_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/cvs_engine.sv
// Sweep state and per-beat step logic: leg sequencing, setpoint, point counter.
// Depends on cvs_pkg; fed by the top level's input register.
module cvs_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,       // item in the input register is consumed
   input  cvs_pkg::item_type  item,
   input  cvs_pkg::cfg_type   cfg,
   output logic               has_result,
   output cvs_pkg::res_type   result
);
   import cvs_pkg::*;

   typedef struct packed {
      leg_type          leg;
      logic [CNT_W-1:0] cyc;
   } pos_type;

   localparam logic signed [PRES_W-1:0] SP_MAX = PRES_W'(2**(VOLT_W-1) - 1);
   localparam logic signed [PRES_W-1:0] SP_MIN = PRES_W'(-(2**(VOLT_W-1)));

   logic                     running_ff, running_in;
   leg_type                  leg_ff, leg_in;
   logic [CNT_W-1:0]         cyc_ff, cyc_in;
   logic [WALK_W-1:0]        walked_ff, walked_in;
   logic signed [PRES_W-1:0] present_ff, present_in;
   logic [POINT_W-1:0]       point_ff, point_in;

   logic signed [VOLT_W-1:0] start_v [3];
   logic signed [VOLT_W-1:0] end_v   [3];
   logic [2:0][VOLT_W-1:0]   leg_dist;
   logic [2:0]               up;

   // next leg; cycle count sticks at its top value
   function automatic pos_type next_pos(input pos_type p);
      pos_type n;
      n = p;
      case (p.leg)
         LEG_OUT:    n.leg = LEG_ACROSS;
         LEG_ACROSS: n.leg = LEG_BACK;
         default: begin
            n.leg = LEG_OUT;
            n.cyc = (p.cyc == '1) ? p.cyc : p.cyc + 1'b1;
         end
      endcase
      return n;
   endfunction

   function automatic logic [VOLT_W-1:0] pick_dist(input logic [2:0][VOLT_W-1:0] d,
                                                   input leg_type l);
      case (l)
         LEG_OUT:    return d[0];
         LEG_ACROSS: return d[1];
         LEG_BACK:   return d[2];
         default:    return '0;
      endcase
   endfunction

   assign start_v[0] = cfg.begin_voltage;
   assign start_v[1] = cfg.vertex_one_voltage;
   assign start_v[2] = cfg.vertex_two_voltage;
   assign end_v[0]   = cfg.vertex_one_voltage;
   assign end_v[1]   = cfg.vertex_two_voltage;
   assign end_v[2]   = cfg.begin_voltage;

   for (genvar k = 0; k < 3; k++) begin : g_leg
      logic signed [VOLT_W:0] diff;
      assign diff        = (VOLT_W+1)'(end_v[k]) - (VOLT_W+1)'(start_v[k]);
      assign leg_dist[k] = diff[VOLT_W] ? VOLT_W'(-diff) : diff[VOLT_W-1:0];
      assign up[k]       = !diff[VOLT_W] && (diff != '0);
   end

   logic [STEP_W-1:0]        step_eff;
   logic                     is_start, tick_live, leg_over, leg_up;
   logic signed [VOLT_W-1:0] seek_start_v;
   logic signed [PRES_W-1:0] present_step;
   logic [WALK_W-1:0]        walked_step;
   pos_type                  seek_pos;
   logic                     seek_run, seek_found;
   logic signed [VOLT_W-1:0] sp_sat;

   always_comb begin
      step_eff  = (cfg.step_size == '0) ? STEP_W'(1) : cfg.step_size;
      is_start  = (item.op == OP_START);
      tick_live = (item.op == OP_TICK) && running_ff;

      case (leg_ff)
         LEG_OUT:    leg_up = up[0];
         LEG_ACROSS: leg_up = up[1];
         LEG_BACK:   leg_up = up[2];
         default:    leg_up = 1'b0;
      endcase

      present_step = leg_up ? present_ff + PRES_W'(step_eff)
                            : present_ff - PRES_W'(step_eff);
      walked_step  = walked_ff + WALK_W'(step_eff);
      leg_over     = walked_step >= WALK_W'(pick_dist(leg_dist, leg_ff));

      // leg search: at most four tries over the three legs
      seek_pos   = is_start ? pos_type'{LEG_OUT, CNT_W'(0)}
                            : next_pos(pos_type'{leg_ff, cyc_ff});
      seek_run   = 1'b1;
      seek_found = 1'b0;
      for (int t = 0; t < 4; t++) begin
         if (seek_run && !seek_found) begin
            if (seek_pos.cyc >= cfg.cycle_count) begin
               seek_run = 1'b0;
            end else if (pick_dist(leg_dist, seek_pos.leg) != '0) begin
               seek_found = 1'b1;
            end else begin
               seek_pos = next_pos(seek_pos);
            end
         end
      end
      if (!seek_found) seek_run = 1'b0;

      case (seek_pos.leg)
         LEG_OUT:    seek_start_v = start_v[0];
         LEG_ACROSS: seek_start_v = start_v[1];
         LEG_BACK:   seek_start_v = start_v[2];
         default:    seek_start_v = cfg.begin_voltage;
      endcase

      if (present_step > SP_MAX)      sp_sat = SP_MAX[VOLT_W-1:0];
      else if (present_step < SP_MIN) sp_sat = SP_MIN[VOLT_W-1:0];
      else                            sp_sat = present_step[VOLT_W-1:0];

      running_in = running_ff;
      leg_in     = leg_ff;
      cyc_in     = cyc_ff;
      walked_in  = walked_ff;
      present_in = present_ff;
      point_in   = point_ff;
      if (fire && is_start) begin
         running_in = seek_run;
         leg_in     = seek_pos.leg;
         cyc_in     = seek_pos.cyc;
         walked_in  = '0;
         point_in   = '0;
         present_in = seek_found ? PRES_W'(seek_start_v) : PRES_W'(cfg.begin_voltage);
      end else if (fire && tick_live) begin
         present_in = present_step;
         walked_in  = walked_step;
         point_in   = point_ff + 1'b1;
         if (leg_over) begin
            running_in = seek_run;
            leg_in     = seek_pos.leg;
            cyc_in     = seek_pos.cyc;
            if (seek_found) begin
               present_in = PRES_W'(seek_start_v);
               walked_in  = '0;
            end
         end
      end

      has_result          = is_start || tick_live;
      result.sample_valid = !is_start;
      result.point_index  = is_start ? '0 : point_ff;
      result.time_ms      = is_start ? '0 : TIME_W'(point_ff) * TIME_W'(cfg.period_ms);
      result.current_out  = is_start ? '0 : item.current_sample;
      result.voltage_out  = is_start ? '0 : item.voltage_sample;
      result.setpoint     = is_start ? cfg.begin_voltage : sp_sat;
      result.relay_on     = running_in;
      result.run_done     = !running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         leg_ff     <= LEG_OUT;
         cyc_ff     <= '0;
         walked_ff  <= '0;
         present_ff <= '0;
         point_ff   <= '0;
      end else begin
         running_ff <= running_in;
         leg_ff     <= leg_in;
         cyc_ff     <= cyc_in;
         walked_ff  <= walked_in;
         present_ff <= present_in;
         point_ff   <= point_in;
      end
   end

   // a live tick always advances the point counter by one
   a_point_step: assert property (@(posedge clock) disable iff (reset)
      fire && tick_live |=> point_ff == $past(point_ff) + 1'b1)
      else $error("point counter did not advance on a live tick");

   // a start clears the walked distance
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      fire && is_start |=> walked_ff == '0)
      else $error("walked distance not cleared by start");

   // idle ticks leave the sweep state alone
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      fire && !is_start && !running_ff |=> $stable(point_ff) && !running_ff)
      else $error("idle tick changed sweep state");

endmodule

>>> rtl/core/cyclic_voltammetry_sweep_core.sv
// Top level of the cyclic voltammetry staircase sweep core.
// Depends on cvs_pkg, cvs_csr and cvs_engine.
//
// Staircase sweep sequencer for cyclic voltammetry. A start beat (op 0)
// clears the counters, reports setpoint = begin voltage and closes the relay
// (relay_on) unless there is nothing to sweep. Each tick beat (op 1) during
// a run carries a raw current and voltage sample; the core returns them with
// the point index, time_ms = point index * period_ms and the next setpoint,
// one step toward the current leg's target. Legs go begin -> vertex one ->
// vertex two -> begin, cycle_count times; a leg ends once the walked
// distance reaches the leg distance (last step may overshoot), the next leg
// restarts at its nominal start, legs with equal ends are skipped. The final
// result of a run has rsp_tlast set and relay_on low. Ticks outside a run
// are consumed and produce no beat. Throughput is one beat per clock while
// rsp_tready is high or the result register is empty: the request beat lands
// in an input register, the step logic and a 16x16 multiplier for the
// timestamp sit between that register and the result register, which
// drives rsp_tvalid and the response beat. The result register decouples
// the sides; req_tready only drops when both the input and the result
// register are full and rsp_tready is low.
// Configuration writes take effect on the next clock and are always
// accepted (csr_ready is tied high); write only with no beat in flight.
module cyclic_voltammetry_sweep_core #(
   parameter int SAMPLE_BITS = 12   // converter resolution, 8 to 12; larger values keep 12 bits
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = current_sample[11:0], voltage_sample[23:12]
   //          tuser = op[0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cvs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [0:0]                         req_tuser,
   // response: tdata = point_index[15:0], time_ms[47:16], current_out[59:48],
   //           voltage_out[71:60], setpoint[88:72], relay_on[89], zero[95:90]
   //           tuser = sample_valid[0]; tlast = run_done
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cvs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cvs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cvs_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import cvs_pkg::*;

   // samples keep only the converter's bits
   localparam int               KEEP_BITS = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
   localparam logic [SMP_W-1:0] SMP_MASK  = SMP_W'((64'd1 << KEEP_BITS) - 64'd1);

   cfg_type  cfg;
   item_type in_item_ff, in_item_in;
   logic     in_valid_ff, in_valid_in;
   res_type  out_res_ff, out_res_in, eng_res;
   logic     out_valid_ff, out_valid_in;
   logic     proceed, eng_has;
   logic     req_fire;

   cvs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register moves on whenever the result register has room
   assign proceed    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proceed;
   assign req_fire   = req_tvalid && req_tready;

   cvs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (proceed),
      .item       (in_item_ff),
      .cfg        (cfg),
      .has_result (eng_has),
      .result     (eng_res)
   );

   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_item_in.op             = req_tuser[0];
         in_item_in.current_sample = req_tdata[SMP_W-1:0] & SMP_MASK;
         in_item_in.voltage_sample = req_tdata[2*SMP_W-1:SMP_W] & SMP_MASK;
         in_valid_in               = 1'b1;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end

      out_res_in   = out_res_ff;
      out_valid_in = out_valid_ff;
      if (proceed) begin
         out_res_in   = eng_res;
         out_valid_in = eng_has;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {RSP_PAD_W'(0), out_res_ff.relay_on, out_res_ff.setpoint,
                          out_res_ff.voltage_out, out_res_ff.current_out,
                          out_res_ff.time_ms, out_res_ff.point_index};
   assign rsp_tuser[0] = out_res_ff.sample_valid;
   assign rsp_tlast    = out_res_ff.run_done;

   // end of run and closed relay never coincide
   a_done_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast != out_res_ff.relay_on))
      else $error("run_done and relay_on disagree");

   // start beats report point zero at time zero
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> out_res_ff.point_index == '0 &&
                                      out_res_ff.time_ms == '0)
      else $error("start beat with nonzero point or time");

   // a held input beat is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proceed |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled input beat lost");

endmodule
